// ----- rtl/olc_pkg.sv -----
`timescale 1ns / 1ps
package olc_pkg;

  // Field widths of the words on the two streaming channels and of the registers.
  localparam int POT_BITS    = 12;
  localparam int DUTY_BITS   = 13;
  localparam int TIME_BITS   = 40;
  localparam int MS16_BITS   = 16;
  localparam int TMO_BITS    = 24;
  localparam int THR_BITS    = 3;

  localparam int WINDOW_SIZE_DEF = 5;

  // Full-scale potentiometer reading.
  localparam logic [POT_BITS-1:0] POT_FULL = POT_BITS'(4095);

  // Configuration port geometry.
  localparam int APB_DATA_BITS = 32;
  localparam int APB_ADDR_BITS = 5;
  localparam int REG_IDX_BITS  = 3;

  // Register indexes.
  localparam logic [REG_IDX_BITS-1:0] REG_TIMEOUT   = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_MIN_DUTY  = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_HYST      = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_THRESHOLD = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_FADE_ONOFF = 3'd4;
  localparam logic [REG_IDX_BITS-1:0] REG_FADE_ADJ  = 3'd5;
  localparam logic [REG_IDX_BITS-1:0] REG_POLL_ACT  = 3'd6;
  localparam logic [REG_IDX_BITS-1:0] REG_POLL_IDLE = 3'd7;

  // Register reset values.
  localparam logic [TMO_BITS-1:0]  RST_TIMEOUT    = TMO_BITS'(10 * 1000);
  localparam logic [DUTY_BITS-1:0] RST_MIN_DUTY   = DUTY_BITS'(410);
  localparam logic [DUTY_BITS-1:0] RST_HYST       = DUTY_BITS'(50);
  localparam logic [THR_BITS-1:0]  RST_THRESHOLD  = THR_BITS'(3);
  localparam logic [MS16_BITS-1:0] RST_FADE_ONOFF = MS16_BITS'(500);
  localparam logic [MS16_BITS-1:0] RST_FADE_ADJ   = MS16_BITS'(100);
  localparam logic [MS16_BITS-1:0] RST_POLL_ACT   = MS16_BITS'(50);
  localparam logic [MS16_BITS-1:0] RST_POLL_IDLE  = MS16_BITS'(200);

  typedef struct packed {
    logic                 motion_raw;
    logic [POT_BITS-1:0]  pot_level;
    logic [TIME_BITS-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic                 lights_on;
    logic                 motion_present;
    logic                 fade_start;
    logic [DUTY_BITS-1:0] duty_goal;
    logic [MS16_BITS-1:0] fade_time_ms;
    logic [MS16_BITS-1:0] next_poll_ms;
  } out_item_t;

  typedef struct packed {
    logic [TMO_BITS-1:0]  vacancy_ms;
    logic [DUTY_BITS-1:0] duty_floor;
    logic [DUTY_BITS-1:0] duty_hysteresis;
    logic [THR_BITS-1:0]  motion_threshold;
    logic [MS16_BITS-1:0] fade_switch_ms;
    logic [MS16_BITS-1:0] fade_trim_ms;
    logic [MS16_BITS-1:0] poll_lit_ms;
    logic [MS16_BITS-1:0] poll_dark_ms;
  } cfg_t;

endpackage

// ----- rtl/olc_cfg_regs.sv -----
`timescale 1ns / 1ps
module olc_cfg_regs import olc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output cfg_t                     cfg
);

  cfg_t                    cfg_r;
  logic [REG_IDX_BITS-1:0] idx;
  logic                    wr_en;

  assign idx   = paddr[APB_ADDR_BITS-1:2];
  assign wr_en = psel && penable && pwrite;
  assign cfg   = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.vacancy_ms       <= RST_TIMEOUT;
      cfg_r.duty_floor       <= RST_MIN_DUTY;
      cfg_r.duty_hysteresis  <= RST_HYST;
      cfg_r.motion_threshold <= RST_THRESHOLD;
      cfg_r.fade_switch_ms   <= RST_FADE_ONOFF;
      cfg_r.fade_trim_ms     <= RST_FADE_ADJ;
      cfg_r.poll_lit_ms      <= RST_POLL_ACT;
      cfg_r.poll_dark_ms     <= RST_POLL_IDLE;
    end else if (wr_en) begin
      case (idx)
        REG_TIMEOUT:    cfg_r.vacancy_ms       <= pwdata[TMO_BITS-1:0];
        REG_MIN_DUTY:   cfg_r.duty_floor       <= pwdata[DUTY_BITS-1:0];
        REG_HYST:       cfg_r.duty_hysteresis  <= pwdata[DUTY_BITS-1:0];
        REG_THRESHOLD:  cfg_r.motion_threshold <= pwdata[THR_BITS-1:0];
        REG_FADE_ONOFF: cfg_r.fade_switch_ms   <= pwdata[MS16_BITS-1:0];
        REG_FADE_ADJ:   cfg_r.fade_trim_ms     <= pwdata[MS16_BITS-1:0];
        REG_POLL_ACT:   cfg_r.poll_lit_ms      <= pwdata[MS16_BITS-1:0];
        REG_POLL_IDLE:  cfg_r.poll_dark_ms     <= pwdata[MS16_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_TIMEOUT:    prdata = APB_DATA_BITS'(cfg_r.vacancy_ms);
      REG_MIN_DUTY:   prdata = APB_DATA_BITS'(cfg_r.duty_floor);
      REG_HYST:       prdata = APB_DATA_BITS'(cfg_r.duty_hysteresis);
      REG_THRESHOLD:  prdata = APB_DATA_BITS'(cfg_r.motion_threshold);
      REG_FADE_ONOFF: prdata = APB_DATA_BITS'(cfg_r.fade_switch_ms);
      REG_FADE_ADJ:   prdata = APB_DATA_BITS'(cfg_r.fade_trim_ms);
      REG_POLL_ACT:   prdata = APB_DATA_BITS'(cfg_r.poll_lit_ms);
      REG_POLL_IDLE:  prdata = APB_DATA_BITS'(cfg_r.poll_dark_ms);
      default:        prdata = '0;
    endcase
  end

endmodule

// ----- rtl/olc_duty_scale.sv -----
`timescale 1ns / 1ps
module olc_duty_scale import olc_pkg::*; (
  input  logic [POT_BITS-1:0]  pot_level,
  input  logic [DUTY_BITS-1:0] duty_floor,
  output logic [DUTY_BITS-1:0] duty
);

  // Computes max(floor(pot_level * 8191 / 4095), duty_floor) with no multiplier.
  // Division by 4095 = 2^12 - 1 uses the series x/4096 * (1 + 2^-12 + 2^-24),
  // which lands on the true quotient or one below it; one compare fixes that.
  localparam int XW = POT_BITS + DUTY_BITS;
  localparam int SW = XW + 2;

  logic [XW-1:0] prod;
  logic [SW-1:0] series;
  logic [SW-1:0] q0;
  logic [SW-1:0] rem;
  logic [SW-1:0] q;
  logic [DUTY_BITS-1:0] scaled;

  always_comb begin
    prod   = ({{DUTY_BITS{1'b0}}, pot_level} << DUTY_BITS) - XW'(pot_level);
    series = SW'(prod) + SW'(prod >> 12) + SW'(prod >> 24);
    q0     = series >> 12;
    rem    = SW'(prod) + q0 - (q0 << 12);
    q      = (rem >= SW'(POT_FULL)) ? q0 + SW'(1) : q0;
    scaled = q[DUTY_BITS-1:0];
    duty   = (scaled < duty_floor) ? duty_floor : scaled;
  end

endmodule

// ----- rtl/olc_core.sv -----
`timescale 1ns / 1ps
module olc_core import olc_pkg::*; #(
  parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output out_item_t result
);

  localparam int CW   = $clog2(WINDOW_SIZE + 1);
  localparam int CMPW = (CW > THR_BITS) ? CW : THR_BITS;

  logic [WINDOW_SIZE-1:0] win_r, win_nxt;
  logic                   lights_r, lights_nxt;
  logic [TIME_BITS-1:0]   last_r, last_nxt;
  logic [DUTY_BITS-1:0]   applied_r, applied_nxt;

  logic [WINDOW_SIZE:0]   win_shift;
  logic [CW-1:0]          count;
  logic                   motion;
  logic [DUTY_BITS-1:0]   desired;
  logic [DUTY_BITS-1:0]   delta;
  logic [TIME_BITS-1:0]   idle_time;
  logic                   fade;
  logic [DUTY_BITS-1:0]   target;
  logic [MS16_BITS-1:0]   ftime;
  logic [MS16_BITS-1:0]   poll;

  olc_duty_scale u_scale (
    .pot_level  (item.pot_level),
    .duty_floor (cfg.duty_floor),
    .duty       (desired)
  );

  always_comb begin
    win_shift = {win_r, item.motion_raw};
    win_nxt   = win_shift[WINDOW_SIZE-1:0];
    count     = '0;
    for (int i = 0; i < WINDOW_SIZE; i++) begin
      count = count + CW'(win_nxt[i]);
    end
    motion = CMPW'(count) >= CMPW'(cfg.motion_threshold);

    lights_nxt  = lights_r;
    last_nxt    = last_r;
    applied_nxt = applied_r;
    fade        = 1'b0;
    target      = '0;
    ftime       = '0;
    delta       = (desired > applied_r) ? desired - applied_r : applied_r - desired;
    idle_time   = '0;

    if (!lights_r) begin
      if (motion) begin
        applied_nxt = desired;
        fade        = 1'b1;
        target      = desired;
        ftime       = cfg.fade_switch_ms;
        last_nxt    = item.now_ms;
        lights_nxt  = 1'b1;
      end
    end else begin
      if (motion) begin
        last_nxt = item.now_ms;
      end
      if (delta > cfg.duty_hysteresis) begin
        applied_nxt = desired;
        fade        = 1'b1;
        target      = desired;
        ftime       = cfg.fade_trim_ms;
      end
      // A turn-off overrides an adjustment made in the same poll.
      idle_time = item.now_ms - last_nxt;
      if (idle_time >= TIME_BITS'(cfg.vacancy_ms)) begin
        applied_nxt = '0;
        fade        = 1'b1;
        target      = '0;
        ftime       = cfg.fade_switch_ms;
        lights_nxt  = 1'b0;
      end
    end

    if (!fade) begin
      target = applied_nxt;
    end
    poll = lights_nxt ? cfg.poll_lit_ms : cfg.poll_dark_ms;
    if (poll == '0) begin
      poll = MS16_BITS'(1);
    end

    result.lights_on      = lights_nxt;
    result.motion_present = motion;
    result.fade_start     = fade;
    result.duty_goal      = target;
    result.fade_time_ms   = ftime;
    result.next_poll_ms   = poll;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r     <= '0;
      lights_r  <= 1'b0;
      last_r    <= '0;
      applied_r <= '0;
    end else if (step) begin
      win_r     <= win_nxt;
      lights_r  <= lights_nxt;
      last_r    <= last_nxt;
      applied_r <= applied_nxt;
    end
  end

endmodule

// ----- rtl/occupancy_light_controller.sv -----
`timescale 1ns / 1ps
// A word accepted into the input register moves into the result register once
// that register is free, and its result word then shows on out_data.
// Throughput: one word per cycle; in_stall rises only when the input register
// holds a word and the result register holds a word that the receiver stalls.
// Reset (rst_n low, synchronous): both stages empty, motion window cleared, lights
// off, last-motion time and applied duty zero, all registers at their defaults.
module occupancy_light_controller import olc_pkg::*; #(
  parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // Poll input channel.
  input  logic                     in_valid,
  output logic                     in_stall,
  input  in_item_t                 in_data,
  // Result channel.
  output logic                     out_valid,
  input  logic                     out_stall,
  output out_item_t                out_data,
  // Configuration port.
  input  logic                     cfg_psel,
  input  logic                     cfg_penable,
  input  logic                     cfg_pwrite,
  input  logic [APB_ADDR_BITS-1:0] cfg_paddr,
  input  logic [APB_DATA_BITS-1:0] cfg_pwdata,
  output logic [APB_DATA_BITS-1:0] cfg_prdata,
  output logic                     cfg_pready
);

  // Stage one holds the accepted poll word; stage two holds its result word.
  logic      in_valid_r, in_valid_nxt;
  in_item_t  in_item_r;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r;

  cfg_t      cfg;
  out_item_t result;
  logic      out_free;
  logic      advance;
  logic      in_take;

  assign cfg_pready = 1'b1;

  olc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  // The controller state advances exactly when a poll moves into the result
  // register, so the next poll in stage one always sees up-to-date state.
  olc_core #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .item   (in_item_r),
    .cfg    (cfg),
    .result (result)
  );

  // The result register frees up when it is empty or being taken this cycle.
  assign out_free = !out_valid_r || !out_stall;
  assign advance  = in_valid_r && out_free;
  // Stage one only blocks when it holds a word that cannot move on.
  assign in_stall = in_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  always_comb begin
    in_valid_nxt  = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_r);
    out_valid_nxt = advance ? 1'b1 : (out_free ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= in_data;
    end
    if (advance) begin
      out_item_r <= result;
    end
  end

endmodule

// ----- rtl/olc_checker.sv -----
`timescale 1ns / 1ps
module olc_checker import olc_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // A result word held back by the receiver stays put.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // With lights off the applied duty is always zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.lights_on |-> out_data.duty_goal == '0)
    else $error("nonzero duty reported with lights off");

  // A fade time is only reported alongside a fade command.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.fade_start |-> out_data.fade_time_ms == '0)
    else $error("fade time without fade command");

  // A word accepted into an idle pipeline yields a result via both registers.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !out_valid && !$past(in_valid && !in_stall) |=> ##1 out_valid)
    else $error("accepted word produced no result");

endmodule

bind occupancy_light_controller olc_checker u_olc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
